// ===== rtl/core/cbsd_pkg.sv =====
// package for the codebook string decompressor: constants, codebook rom and its entry type
package cbsd_pkg;

    // width of the running character count
    localparam int COUNT_WIDTH = 16;

    // escape bytes
    localparam logic [7:0] BYTE_ONE = 8'd254;
    localparam logic [7:0] BYTE_RUN = 8'd255;

    // one codebook entry: first character in the top byte
    typedef struct packed {
        logic [2:0]  len;
        logic [39:0] chars;
    } cbsd_rom_t;

    // codebook lookup, strings of zero to five characters
    function automatic cbsd_rom_t cbsd_rom(input logic [7:0] idx);
        logic [39:0] s;
        logic [2:0]  n;
        cbsd_rom_t   r;
        s = '0;
        case (idx)
            8'd1: s = "32";       8'd2: s = "2ccc";     8'd3: s = "CC=C3";    8'd4: s = "[N+";
            8'd5: s = "=";        8'd6: s = "+";        8'd7: s = "NN=";      8'd8: s = "]1C";
            8'd9: s = "=C3)";     8'd10: s = "-";       8'd11: s = "C(N";     8'd12: s = "=C2)C";
            8'd13: s = "#";       8'd14: s = "2N";      8'd15: s = ".";       8'd16: s = "1=C(";
            8'd17: s = "O)O";     8'd18: s = "F";       8'd19: s = "-]";      8'd20: s = "C)c";
            8'd21: s = "=O)O";    8'd22: s = "=C3";     8'd23: s = "2cccc";   8'd24: s = ")F";
            8'd25: s = "=S";      8'd26: s = "/";       8'd27: s = "H]";      8'd28: s = "(cc2";
            8'd29: s = "cn";      8'd30: s = "c2)";     8'd31: s = "CO";      8'd32: s = "P";
            8'd33: s = "2=CC=";   8'd34: s = "Cc1cc";   8'd35: s = "2)C";     8'd36: s = "(CC";
            8'd37: s = "(cc";     8'd38: s = "3=CC";    8'd39: s = "4=CC=";   8'd40: s = "C=C";
            8'd41: s = "1)C(=";   8'd42: s = "(C)C";    8'd43: s = "c4ccc";   8'd44: s = "3)";
            8'd45: s = "C(C";     8'd46: s = "ccc";     8'd47: s = "[N+](";   8'd48: s = "N(CC";
            8'd49: s = "(C)C)";   8'd50: s = "CC(=O";   8'd51: s = "2)C(=";   8'd52: s = "(=C";
            8'd53: s = "O)C";     8'd54: s = "(=O)O";   8'd55: s = "=C";      8'd56: s = "=CC(=";
            8'd57: s = "1=CC=";   8'd58: s = "CCC";     8'd59: s = "CCCCC";   8'd60: s = "C1=CC";
            8'd61: s = ")N";      8'd62: s = "=O)C";    8'd63: s = "OC";      8'd64: s = "F)";
            8'd65: s = "C(=O)";   8'd66: s = "(=O)C";   8'd67: s = "(=O)N";   8'd68: s = "NC(=O";
            8'd69: s = "=CC=C";   8'd70: s = "[C@H]";   8'd71: s = "S(=O)";   8'd72: s = "[C@@H";
            8'd73: s = "c1ccc";   8'd74: s = "c2ccc";   8'd75: s = ")C(=O";   8'd76: s = "C(C=C";
            8'd77: s = "c3ccc";   8'd78: s = "(C=C";    8'd79: s = "=C(C=";   8'd80: s = "C(=C";
            8'd81: s = "CC1=C";   8'd82: s = "(=O)";    8'd83: s = ")OC";     8'd84: s = "c(c";
            8'd85: s = "(C";      8'd86: s = "CC(C)";   8'd87: s = ")C";      8'd88: s = ")NC";
            8'd89: s = "1)C";     8'd90: s = "CC";      8'd91: s = "COC1=";   8'd92: s = "CC=C";
            8'd93: s = "N(C";     8'd94: s = "2CCC";    8'd95: s = "(cc2)";   8'd96: s = "2C";
            8'd97: s = "CC(=C";   8'd98: s = "CCCC";    8'd99: s = ")Cl";     8'd100: s = "(c(c";
            8'd101: s = "C2=CC";  8'd102: s = "(C)";    8'd103: s = "O)NC";   8'd104: s = "OC(=O";
            8'd105: s = "C3=CC";  8'd106: s = "=N";     8'd107: s = "4)C";    8'd108: s = "ccccc";
            8'd109: s = "1)";     8'd110: s = "1CC";    8'd111: s = "2=C";    8'd112: s = "CN(CC";
            8'd113: s = "N2C";    8'd114: s = "c1cc(";  8'd115: s = "2)";     8'd116: s = "NC";
            8'd117: s = "c(cc1";  8'd118: s = "=O)[";   8'd119: s = "O-]";    8'd120: s = "CC=C4";
            8'd121: s = "3C";     8'd122: s = "(C(=O";  8'd123: s = "C3";     8'd124: s = "CC1";
            8'd125: s = "2CC";    8'd126: s = "(";      8'd127: s = "CC=C2";  8'd128: s = "l)Cl";
            8'd129: s = "cc2)";   8'd130: s = "O)";     8'd131: s = "6";      8'd132: s = "C5";
            8'd133: s = "NC(=S";  8'd134: s = "l)";     8'd135: s = "(c2";    8'd136: s = "c1)";
            8'd137: s = "n1";     8'd138: s = "1=C";    8'd139: s = "]";      8'd140: s = "(C2=";
            8'd141: s = "C)";     8'd142: s = "Cc1c";   8'd143: s = "c2";     8'd144: s = "2=O)C";
            8'd145: s = "SCC";    8'd146: s = "#N";     8'd147: s = "CCC1";   8'd148: s = "2)Cl";
            8'd149: s = ")[C@";   8'd150: s = "=O)c";   8'd151: s = "O)OC";   8'd152: s = "n";
            8'd153: s = "=C1";    8'd154: s = "O)O)";   8'd155: s = ")O";     8'd156: s = "[C";
            8'd157: s = ")CO";    8'd158: s = ")CCC";   8'd159: s = ")F)";    8'd160: s = "1=C(C";
            8'd161: s = ")NCC";   8'd162: s = "c2cc(";  8'd163: s = "4CCC";   8'd164: s = "c(n";
            8'd165: s = "CC=C1";  8'd166: s = ")C(C)";  8'd167: s = "CCN";    8'd168: s = ")C3";
            8'd169: s = "N(C)C";  8'd170: s = "(C(=C";  8'd171: s = "c";      8'd172: s = "2)O";
            8'd173: s = "=NN";    8'd174: s = ")C(";    8'd175: s = "C1)C";   8'd176: s = "C1C";
            8'd177: s = "C1";     8'd178: s = "Oc1cc";  8'd179: s = "CNC(=";  8'd180: s = "OC)C";
            8'd181: s = "CCC(C";  8'd182: s = ")C)C";   8'd183: s = "=O)";    8'd184: s = "C[C@@";
            8'd185: s = "O";      8'd186: s = "]([C@";  8'd187: s = "/C=C";   8'd188: s = "C3)C";
            8'd189: s = "3=";     8'd190: s = "cc2";    8'd191: s = "3";      8'd192: s = "C(C)C";
            8'd193: s = "SC";     8'd194: s = "5";      8'd195: s = "4)";     8'd196: s = "CCOC";
            8'd197: s = "Br";     8'd198: s = "H](";    8'd199: s = "CC(C(";  8'd200: s = "c(c(c";
            8'd201: s = "1";      8'd202: s = "cc(";    8'd203: s = "C(";     8'd204: s = "C=C2";
            8'd205: s = "=C(C";   8'd206: s = ")C2=";   8'd207: s = "C2=C(";  8'd208: s = "C1CC";
            8'd209: s = "c5ccc";  8'd210: s = "1)CC";   8'd211: s = "(=N";    8'd212: s = ")c2cc";
            8'd213: s = "(F)(F";  8'd214: s = "2";      8'd215: s = "1)OC";   8'd216: s = "CCOC(";
            8'd217: s = "O)N";    8'd218: s = "cc";     8'd219: s = ")CC";    8'd220: s = "C)C";
            8'd221: s = "C=C(C";  8'd222: s = "[nH]";   8'd223: s = "1C";     8'd224: s = "CN";
            8'd225: s = "COC";    8'd226: s = ")";      8'd227: s = "c3c";    8'd228: s = "(O";
            8'd229: s = "(c";     8'd230: s = "cc3";    8'd231: s = "c1";     8'd232: s = ")O)";
            8'd233: s = "3CCC";   8'd234: s = "[NH+]";  8'd235: s = "C=C1";   8'd236: s = "OCC";
            8'd237: s = "1C(=O";  8'd238: s = "(cc3)";  8'd239: s = "3)C(=";  8'd240: s = "N=C";
            8'd241: s = ")N(C";   8'd242: s = "nc";     8'd243: s = "c2c";    8'd244: s = "C";
            8'd245: s = "C2";     8'd246: s = "](C";    8'd247: s = "1)NC";   8'd248: s = "Cl";
            8'd249: s = "cc(cc";  8'd250: s = "4";      8'd251: s = "COc1c";  8'd252: s = "N";
            8'd253: s = "CCN(C";
            default: s = '0;
        endcase
        // strings are right-justified: count the used bytes, then move the first to the top
        n = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (s[i*8 +: 8] != 8'd0)
            begin
                n = n + 3'd1;
            end
        end
        r.len   = n;
        r.chars = s << (6'd8 * (6'd5 - {3'd0, n}));
        return r;
    endfunction

endpackage

// ===== rtl/core/codebook_string_decompressor_unit.sv =====
// codebook string decompressor: byte decode, codebook rom read, character emitter
//
// Compressed bytes enter on the s_ stream, one per request, and characters leave on the m_
// stream, one per request. A byte of 0 to 253 expands to its codebook string of zero to five
// characters; 254 passes the next byte verbatim; 255 takes the next byte as a length L and
// passes the following L+1 bytes verbatim. The emitter sends one character per cycle while
// m_tready does not stall it, so the sustained rate is one byte per cycle for verbatim data;
// a byte that yields several results keeps its successor in the input stage, and so holds
// the s_ stream, until its last result is sent. With the emitter idle, a byte's first result
// appears on the m_ stream once it has passed the input stage with the codebook rom read,
// the emitter job register and the output register, in that order.
// Before each codebook string or verbatim run the running count is checked against
// out_capacity (cfg_wr_en / cfg_wr_data); a failed check sends a status result with the
// overflow flag and drops all bytes up to the end of the stream. s_tlast ends a stream; its
// last result has stream done set, and truncated set when the stream ended inside an escape.
module codebook_string_decompressor_unit
    import cbsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // compressed input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    // character output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_char, [23:8] total_length
    output logic        m_tlast,   // run_last
    output logic [3:0]  m_tuser    // [0] char_valid, [1] stream_done, [2] overflow, [3] truncated
);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ONE    = 2'd1;
    localparam logic [1:0] MODE_LEN    = 2'd2;
    localparam logic [1:0] MODE_RUN    = 2'd3;

    localparam int LIM_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

    // capacity check: prod + n <= min(capacity, counter max)
    function automatic logic fits(input logic [COUNT_WIDTH-1:0] prod,
                                  input logic [15:0] cap,
                                  input logic [8:0] n);
        logic [LIM_W-1:0] cap_e;
        logic [LIM_W-1:0] cmax_e;
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] sum;
        cap_e  = LIM_W'(cap);
        cmax_e = LIM_W'({COUNT_WIDTH{1'b1}});
        lim    = (cap_e < cmax_e) ? cap_e : cmax_e;
        sum    = LIM_W'(prod) + LIM_W'(n);
        return sum <= lim;
    endfunction

    // configuration
    logic [15:0] cap_reg;

    // decode state
    logic [1:0]             mode_reg, mode_next;
    logic [8:0]             vrem_reg, vrem_next;
    logic [COUNT_WIDTH-1:0] prod_reg, prod_next;
    logic                   err_reg, err_next;

    // input stage with registered rom data
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    cbsd_rom_t  s1_rom_reg;

    // emitter job
    logic        job_valid_reg;
    logic [39:0] job_chars_reg;
    logic [2:0]  job_left_reg;
    logic [15:0] job_total_reg;
    logic        job_status_reg;
    logic        job_done_reg;
    logic        job_trunc_reg;
    logic        job_ovf_reg;

    // output register
    logic        m_valid_reg;
    logic [7:0]  out_char_reg;
    logic [15:0] out_total_reg;
    logic        out_last_reg;
    logic [3:0]  out_user_reg;

    // handshake flow
    logic out_free;
    logic emit;
    logic job_end;
    logic job_free;
    logic s1_adv;
    logic in_acc;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = job_valid_reg && out_free;
    assign job_end  = emit && (job_left_reg == 3'd1);
    assign job_free = !job_valid_reg || job_end;
    assign s1_adv   = s1_valid_reg && job_free;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;

    // decode of the byte in the input stage
    logic        fail;
    logic [2:0]  nchar;
    logic [39:0] dec_chars;
    logic        trunc;
    logic        job_load;
    logic        job_status;

    always_comb
    begin
        fail      = 1'b0;
        nchar     = 3'd0;
        dec_chars = s1_rom_reg.chars;
        mode_next = mode_reg;
        vrem_next = vrem_reg;
        prod_next = prod_reg;
        err_next  = err_reg;
        trunc     = 1'b0;
        if (!err_reg)
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (s1_byte_reg == BYTE_ONE)
                    begin
                        if (fits(prod_reg, cap_reg, 9'd1))
                        begin
                            mode_next = MODE_ONE;
                        end
                        else
                        begin
                            fail = 1'b1;
                        end
                    end
                    else if (s1_byte_reg == BYTE_RUN)
                    begin
                        mode_next = MODE_LEN;
                    end
                    else if (fits(prod_reg, cap_reg, {6'd0, s1_rom_reg.len}))
                    begin
                        nchar     = s1_rom_reg.len;
                        prod_next = prod_reg + COUNT_WIDTH'(s1_rom_reg.len);
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                MODE_ONE:
                begin
                    nchar     = 3'd1;
                    dec_chars = {s1_byte_reg, 32'd0};
                    prod_next = prod_reg + COUNT_WIDTH'(1);
                    mode_next = MODE_NORMAL;
                end
                MODE_LEN:
                begin
                    if (fits(prod_reg, cap_reg, {1'b0, s1_byte_reg} + 9'd1))
                    begin
                        vrem_next = {1'b0, s1_byte_reg} + 9'd1;
                        mode_next = MODE_RUN;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                default:
                begin
                    nchar     = 3'd1;
                    dec_chars = {s1_byte_reg, 32'd0};
                    prod_next = prod_reg + COUNT_WIDTH'(1);
                    if (vrem_reg != 9'd0)
                    begin
                        vrem_next = vrem_reg - 9'd1;
                    end
                    if (vrem_next == 9'd0)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
            endcase
            if (fail)
            begin
                err_next  = 1'b1;
                mode_next = MODE_NORMAL;
                vrem_next = 9'd0;
            end
        end
        job_status = fail || (s1_last_reg && (nchar == 3'd0));
        job_load   = job_status || (nchar != 3'd0);
        if (s1_last_reg)
        begin
            trunc = !err_next && (mode_next != MODE_NORMAL);
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 16'hFFFF;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // decode state, cleared at stream end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            vrem_reg <= 9'd0;
            prod_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                mode_reg <= MODE_NORMAL;
                vrem_reg <= 9'd0;
                prod_reg <= '0;
                err_reg  <= 1'b0;
            end
            else
            begin
                mode_reg <= mode_next;
                vrem_reg <= vrem_next;
                prod_reg <= prod_next;
                err_reg  <= err_next;
            end
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload and codebook rom read
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
            s1_rom_reg  <= cbsd_rom(s_tdata);
        end
    end

    // emitter job control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_left_reg  <= 3'd0;
        end
        else if (s1_adv && job_load)
        begin
            job_valid_reg <= 1'b1;
            job_left_reg  <= job_status ? 3'd1 : nchar;
        end
        else if (emit)
        begin
            job_left_reg <= job_left_reg - 3'd1;
            if (job_end)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    // emitter job payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && job_load)
        begin
            job_chars_reg  <= dec_chars;
            job_total_reg  <= job_status ? 16'(prod_reg) : 16'(prod_reg) + 16'd1;
            job_status_reg <= job_status;
            job_done_reg   <= s1_last_reg;
            job_trunc_reg  <= trunc;
            job_ovf_reg    <= err_next;
        end
        else if (emit)
        begin
            job_chars_reg <= {job_chars_reg[31:0], 8'd0};
            job_total_reg <= job_total_reg + 16'd1;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= job_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg  <= job_status_reg ? 8'd0 : job_chars_reg[39:32];
            out_total_reg <= job_total_reg;
            out_last_reg  <= (job_left_reg == 3'd1);
            out_user_reg  <= {job_trunc_reg && (job_left_reg == 3'd1),
                              job_ovf_reg,
                              job_done_reg && (job_left_reg == 3'd1),
                              !job_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_total_reg, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule
